// ===== hw/rtl/qte_pkg.sv =====
// shared types, constants and helpers for the quaternion to euler converter
package qte_pkg;

    localparam int QUAT_WIDTH    = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int THR_WIDTH     = 16;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd32735;

    localparam int FW      = 21;  // q1.20 working format
    localparam int PW      = 42;  // q2.40 products
    localparam int CW      = 48;  // cordic datapath
    localparam int TW      = 29;  // asin argument in q.28
    localparam int SQ_BITS = 29;  // square root result bits
    localparam int RW      = 58;  // square root remainder
    localparam int NW      = 60;  // pole compare
    localparam int AW32    = 32;  // angle accumulator

    localparam logic signed [CW-1:0] FIX_ONE  = 48'sh0100_0000_0000;
    localparam logic signed [CW-1:0] SAT_LIM  = 48'sh0080_0000_0000;
    localparam logic [RW-1:0]        SQ_ONE   = 58'h100_0000_0000_0000;
    localparam logic [AW32-1:0]      QUARTER_TURN = 32'h4000_0000;
    localparam logic [AW32-1:0]      HALF_TURN    = 32'h8000_0000;
    localparam logic [AW32-1:0]      THREE_QUARTER_TURN = 32'hC000_0000;

    localparam logic [AW32-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef enum logic [1:0] {
        PC_REGULAR = 2'd0,
        PC_NORTH   = 2'd1,
        PC_SOUTH   = 2'd2
    } t_pole;

    typedef enum logic [1:0] {
        SAT_NONE = 2'd0,
        SAT_POS  = 2'd1,
        SAT_NEG  = 2'd2
    } t_sat;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
    } t_quat;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] yaw_angle;
        logic [ANGLE_WIDTH-1:0] pitch_angle;
        logic [ANGLE_WIDTH-1:0] roll_angle;
        logic [1:0]             pole_case;
    } t_result;

    typedef struct packed {
        t_pole                 pcase;
        t_sat                  psat;
        logic signed [CW-1:0]  yaw_y;
        logic signed [CW-1:0]  yaw_x;
        logic signed [CW-1:0]  roll_y;
        logic signed [CW-1:0]  roll_x;
        logic signed [TW-1:0]  t;
    } t_side;

    typedef struct packed {
        t_side                side;
        logic [RW-1:0]        rem;
        logic [SQ_BITS-1:0]   root;
    } t_sq;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [AW32-1:0]      ang;
        logic                 done;
    } t_cord;

    function automatic logic signed [FW-1:0] to_q20(logic signed [QUAT_WIDTH-1:0] v);
        logic signed [QUAT_WIDTH+FW-1:0] e;
        e = {v, {FW{1'b0}}};
        e = e >>> QUAT_WIDTH;
        return e[FW-1:0];
    endfunction

    function automatic logic [ANGLE_WIDTH-1:0] quant(logic [AW32-1:0] a);
        logic [AW32:0] v;
        v = {1'b0, a} + ((33'd1 << (AW32 - ANGLE_WIDTH)) >> 1);
        return v[AW32-1 -: ANGLE_WIDTH];
    endfunction

endpackage

// ===== hw/rtl/qte_front.sv =====
// products, sums, pole test and asin argument ahead of the square root row
module qte_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  qte_pkg::t_quat                  i_quat,
    input  logic [qte_pkg::THR_WIDTH-1:0]   i_thr,
    output logic                            o_valid,
    output qte_pkg::t_sq                    o_sq
);

    localparam int CW = qte_pkg::CW;
    localparam int PW = qte_pkg::PW;
    localparam int FW = qte_pkg::FW;
    localparam int NW = qte_pkg::NW;
    localparam int RW = qte_pkg::RW;
    localparam int TW = qte_pkg::TW;

    logic signed [FW-1:0] w_x, w_y, w_z, w_w;

    logic                 r1_v;
    logic signed [PW-1:0] r1_xx, r1_yy, r1_zz, r1_ww, r1_xw, r1_yz, r1_wy, r1_zx, r1_wz, r1_xy;
    logic signed [FW-1:0] r1_x, r1_y;

    logic                 r2_v;
    logic signed [CW-1:0] r2_norm, r2_test, r2_yaw_y, r2_yaw_x, r2_roll_y, r2_roll_x;
    logic signed [FW-1:0] r2_x, r2_y;

    logic                 r3_v;
    logic signed [NW-1:0] r3_lhs, r3_rhs;
    logic signed [RW-1:0] r3_tsq;
    logic signed [TW-1:0] r3_t;
    qte_pkg::t_sat        r3_psat;
    logic signed [CW-1:0] r3_yaw_y, r3_yaw_x, r3_roll_y, r3_roll_x;
    logic signed [FW-1:0] r3_x, r3_y;

    logic                 r4_v;
    qte_pkg::t_sq         r4_sq;

    logic signed [CW-1:0] w_tfull;
    logic signed [TW-1:0] w_t;
    logic signed [NW-1:0] w_thr;
    qte_pkg::t_sat        w_psat;
    qte_pkg::t_sq         n_sq;

    assign w_x = qte_pkg::to_q20(i_quat.quat_x);
    assign w_y = qte_pkg::to_q20(i_quat.quat_y);
    assign w_z = qte_pkg::to_q20(i_quat.quat_z);
    assign w_w = qte_pkg::to_q20(i_quat.quat_w);

    always_ff @(posedge i_clk) begin
        r1_xx <= w_x * w_x;
        r1_yy <= w_y * w_y;
        r1_zz <= w_z * w_z;
        r1_ww <= w_w * w_w;
        r1_xw <= w_x * w_w;
        r1_yz <= w_y * w_z;
        r1_wy <= w_w * w_y;
        r1_zx <= w_z * w_x;
        r1_wz <= w_w * w_z;
        r1_xy <= w_x * w_y;
        r1_x  <= w_x;
        r1_y  <= w_y;
    end

    always_ff @(posedge i_clk) begin
        r2_norm   <= CW'(r1_xx) + CW'(r1_yy) + CW'(r1_zz) + CW'(r1_ww);
        r2_test   <= CW'(r1_xw) - CW'(r1_yz);
        r2_yaw_y  <= (CW'(r1_wy) + CW'(r1_zx)) <<< 1;
        r2_yaw_x  <= qte_pkg::FIX_ONE - ((CW'(r1_xx) + CW'(r1_yy)) <<< 1);
        r2_roll_y <= (CW'(r1_wz) + CW'(r1_xy)) <<< 1;
        r2_roll_x <= qte_pkg::FIX_ONE - ((CW'(r1_zz) + CW'(r1_xx)) <<< 1);
        r2_x      <= r1_x;
        r2_y      <= r1_y;
    end

    // asin argument 2*test in q.28
    assign w_tfull = r2_test >>> 11;
    assign w_t     = w_tfull[TW-1:0];
    assign w_thr   = NW'(signed'({1'b0, i_thr}));

    always_comb begin
        if (r2_test >= qte_pkg::SAT_LIM) begin
            w_psat = qte_pkg::SAT_POS;
        end else if (r2_test <= -qte_pkg::SAT_LIM) begin
            w_psat = qte_pkg::SAT_NEG;
        end else begin
            w_psat = qte_pkg::SAT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_lhs    <= NW'(r2_test) <<< 16;
        r3_rhs    <= w_thr * NW'(r2_norm);
        r3_tsq    <= RW'(w_t) * RW'(w_t);
        r3_t      <= w_t;
        r3_psat   <= w_psat;
        r3_yaw_y  <= r2_yaw_y;
        r3_yaw_x  <= r2_yaw_x;
        r3_roll_y <= r2_roll_y;
        r3_roll_x <= r2_roll_x;
        r3_x      <= r2_x;
        r3_y      <= r2_y;
    end

    always_comb begin
        n_sq.side.psat   = r3_psat;
        n_sq.side.roll_y = r3_roll_y;
        n_sq.side.roll_x = r3_roll_x;
        n_sq.side.t      = r3_t;
        n_sq.rem         = qte_pkg::SQ_ONE - r3_tsq;
        n_sq.root        = '0;
        if (r3_lhs > r3_rhs) begin
            n_sq.side.pcase = qte_pkg::PC_NORTH;
        end else if (r3_lhs < -r3_rhs) begin
            n_sq.side.pcase = qte_pkg::PC_SOUTH;
        end else begin
            n_sq.side.pcase = qte_pkg::PC_REGULAR;
        end
        // pole cases steer the yaw unit onto atan2(y, x)
        if (n_sq.side.pcase == qte_pkg::PC_REGULAR) begin
            n_sq.side.yaw_y = r3_yaw_y;
            n_sq.side.yaw_x = r3_yaw_x;
        end else begin
            n_sq.side.yaw_y = CW'(r3_y);
            n_sq.side.yaw_x = CW'(r3_x);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sq <= n_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    assign o_valid = r4_v;
    assign o_sq    = r4_sq;

endmodule

// ===== hw/rtl/qte_sqrt_cell.sv =====
// one result bit of the restoring square root, registered
module qte_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  qte_pkg::t_sq  i_sq,
    output logic          o_valid,
    output qte_pkg::t_sq  o_sq
);

    localparam int RW = qte_pkg::RW;
    localparam int TW = qte_pkg::SQ_BITS;

    logic [RW+1:0] w_inc;
    logic          w_ge;
    qte_pkg::t_sq  n_sq;
    qte_pkg::t_sq  r_sq;
    logic          r_valid;

    // (2*root + 2^bit) * 2^bit
    assign w_inc = ((RW+2)'(i_sq.root) << (BIT + 1)) + ((RW+2)'(1) << (2 * BIT));
    assign w_ge  = {2'b00, i_sq.rem} >= w_inc;

    always_comb begin
        n_sq = i_sq;
        if (w_ge) begin
            n_sq.rem  = i_sq.rem - w_inc[RW-1:0];
            n_sq.root = i_sq.root | (TW'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule

// ===== hw/rtl/qte_cordic_cell.sv =====
// one vectoring micro-rotation of the cordic row
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  qte_pkg::t_cord  i_c,
    output qte_pkg::t_cord  o_c
);

    localparam int CW = qte_pkg::CW;

    logic signed [CW-1:0] w_sx, w_sy;
    qte_pkg::t_cord       n_c;
    qte_pkg::t_cord       r_c;

    assign w_sx = i_c.x >>> IDX;
    assign w_sy = i_c.y >>> IDX;

    always_comb begin
        n_c = i_c;
        if (!i_c.done) begin
            if (i_c.y > 0) begin
                n_c.x   = i_c.x + w_sy;
                n_c.y   = i_c.y - w_sx;
                n_c.ang = i_c.ang + qte_pkg::ATAN_TAB[IDX];
            end else begin
                n_c.x   = i_c.x - w_sy;
                n_c.y   = i_c.y + w_sx;
                n_c.ang = i_c.ang - qte_pkg::ATAN_TAB[IDX];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    assign o_c = r_c;

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// atan2 unit: axis and half-turn preparation followed by a row of cordic cells
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES
) (
    input  logic                         i_clk,
    input  logic signed [qte_pkg::CW-1:0] i_y,
    input  logic signed [qte_pkg::CW-1:0] i_x,
    output logic [qte_pkg::AW32-1:0]     o_ang
);

    qte_pkg::t_cord n_prep;
    qte_pkg::t_cord r_prep;
    qte_pkg::t_cord w_c [STAGES+1];

    always_comb begin
        n_prep.x    = i_x;
        n_prep.y    = i_y;
        n_prep.ang  = '0;
        n_prep.done = 1'b0;
        if (i_x == 0) begin
            n_prep.done = 1'b1;
            if (i_y > 0) begin
                n_prep.ang = qte_pkg::QUARTER_TURN;
            end else if (i_y < 0) begin
                n_prep.ang = qte_pkg::THREE_QUARTER_TURN;
            end
        end else begin
            if (i_x < 0) begin
                n_prep.x   = -i_x;
                n_prep.y   = -i_y;
                n_prep.ang = qte_pkg::HALF_TURN;
            end
            // on an axis: nothing left to rotate
            if (i_y == 0) begin
                n_prep.done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    assign w_c[0] = r_prep;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        qte_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_c   (w_c[g]),
            .o_c   (w_c[g+1])
        );
    end

    assign o_ang = w_c[STAGES].ang;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// top level: quaternion to yaw, pitch and roll binary angles
// usage
//   request channel: drive i_quat and pulse start; busy is always low, so a
//   request is taken on every cycle that start is high, one per clock
//   result channel: o_done is high for one cycle with o_result holding yaw,
//   pitch, roll (65536 = one turn) and the pole case; the receiver cannot
//   stall, results come out in request order with no gaps in a burst
//   pipeline: 4 front stages for products, sums and pole compare, 29 square
//   root cells for the asin cosine term, one cordic preparation stage plus one
//   cordic cell per stage, one output register
//   throughput: one request per cycle, each unit is a row of cells
//   config: apb register 0 at byte address 0 holds pole_threshold (q0.16);
//   write it only while no request is in flight
//   reset: synchronous, active low; clears the pipeline valids and sets
//   pole_threshold to 0.4995
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qte_pkg::t_quat    i_quat,
    output logic              o_done,
    output qte_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = qte_pkg::CW;
    localparam int NB = qte_pkg::SQ_BITS;
    localparam logic REG_THR = 1'b0;

    logic [qte_pkg::THR_WIDTH-1:0] r_thr;

    logic                 w_sv [NB+1];
    qte_pkg::t_sq         w_sq [NB+1];

    logic signed [CW-1:0] w_pitch_x, w_pitch_y;
    logic [31:0]          w_yaw_ang, w_pitch_ang, w_roll_ang;

    logic [CORDIC_STAGES:0] r_dv;
    qte_pkg::t_pole         r_dcase [CORDIC_STAGES+1];
    qte_pkg::t_sat          r_dsat  [CORDIC_STAGES+1];

    logic [31:0]          w_yaw, w_pitch, w_roll;
    qte_pkg::t_pole       w_case;
    qte_pkg::t_sat        w_sat;
    logic                 r_done;
    qte_pkg::t_result     r_result;

    // config register
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qte_pkg::THR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_THR)) begin
            r_thr <= pwdata[qte_pkg::THR_WIDTH-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THR) ? 32'(r_thr) : 32'd0;

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_quat  (i_quat),
        .i_thr   (r_thr),
        .o_valid (w_sv[0]),
        .o_sq    (w_sq[0])
    );

    for (genvar g = 0; g < NB; g++) begin : g_sqrt
        qte_sqrt_cell #(
            .BIT (NB - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sv[g]),
            .i_sq    (w_sq[g]),
            .o_valid (w_sv[g+1]),
            .o_sq    (w_sq[g+1])
        );
    end

    assign w_pitch_y = CW'(w_sq[NB].side.t);
    assign w_pitch_x = CW'(signed'({1'b0, w_sq[NB].root}));

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_yaw (
        .i_clk (i_clk),
        .i_y   (w_sq[NB].side.yaw_y),
        .i_x   (w_sq[NB].side.yaw_x),
        .o_ang (w_yaw_ang)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_roll (
        .i_clk (i_clk),
        .i_y   (w_sq[NB].side.roll_y),
        .i_x   (w_sq[NB].side.roll_x),
        .o_ang (w_roll_ang)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_pitch (
        .i_clk (i_clk),
        .i_y   (w_pitch_y),
        .i_x   (w_pitch_x),
        .o_ang (w_pitch_ang)
    );

    // case codes ride alongside the cordic rows
    always_ff @(posedge i_clk) begin
        r_dcase[0] <= w_sq[NB].side.pcase;
        r_dsat[0]  <= w_sq[NB].side.psat;
        for (int i = 1; i <= CORDIC_STAGES; i++) begin
            r_dcase[i] <= r_dcase[i-1];
            r_dsat[i]  <= r_dsat[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            r_dv <= {r_dv[CORDIC_STAGES-1:0], w_sv[NB]};
        end
    end

    assign w_case = r_dcase[CORDIC_STAGES];
    assign w_sat  = r_dsat[CORDIC_STAGES];

    always_comb begin
        w_yaw   = w_yaw_ang;
        w_pitch = w_pitch_ang;
        w_roll  = w_roll_ang;
        if (w_case == qte_pkg::PC_NORTH) begin
            w_yaw   = w_yaw_ang << 1;
            w_pitch = qte_pkg::QUARTER_TURN;
            w_roll  = '0;
        end else if (w_case == qte_pkg::PC_SOUTH) begin
            w_yaw   = 32'd0 - (w_yaw_ang << 1);
            w_pitch = qte_pkg::THREE_QUARTER_TURN;
            w_roll  = '0;
        end else if (w_sat == qte_pkg::SAT_POS) begin
            w_pitch = qte_pkg::QUARTER_TURN;
        end else if (w_sat == qte_pkg::SAT_NEG) begin
            w_pitch = qte_pkg::THREE_QUARTER_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.yaw_angle   <= qte_pkg::quant(w_yaw);
        r_result.pitch_angle <= qte_pkg::quant(w_pitch);
        r_result.roll_angle  <= qte_pkg::quant(w_roll);
        r_result.pole_case   <= w_case;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv[CORDIC_STAGES];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
